// ===== rtl/isingm_pkg.sv =====
// Shared constants, types and helper functions for the Ising Metropolis spin-flip block.
`default_nettype none
package isingm_pkg;

  localparam int LATTICE_WIDTH  = 8;
  localparam int LATTICE_HEIGHT = 8;
  localparam int SITE_COUNT     = LATTICE_WIDTH * LATTICE_HEIGHT;

  localparam int X_W      = $clog2(LATTICE_WIDTH);
  localparam int Y_W      = $clog2(LATTICE_HEIGHT);
  localparam int ADDR_W   = $clog2(SITE_COUNT);
  localparam int SUM_W    = $clog2(SITE_COUNT) + 2;

  localparam int COORD_IN_W  = 3;
  localparam int RAND_W      = 16;
  localparam int THRESH_W    = 17;
  localparam int OUT_SUM_W   = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int NB_CNT_W    = 3;
  localparam int SEL_W       = 3;

  localparam logic REQ_ATTEMPT = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESH_HIGH = 1'b1;

  localparam logic [SEL_W-1:0] SEL_CENTRE = 3'd0;
  localparam logic [SEL_W-1:0] SEL_LEFT   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_RIGHT  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_UP     = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DOWN   = 3'd4;

  typedef logic [X_W-1:0]    x_coord_t;
  typedef logic [Y_W-1:0]    y_coord_t;
  typedef logic [ADDR_W-1:0] site_addr_t;

  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic [SEL_W-1:0] rd_sel;
    logic             commit;
  } dp_cmd_t;

  function automatic x_coord_t wrap_x(input logic [COORD_IN_W-1:0] v);
    logic [COORD_IN_W-1:0] t;
    t = v;
    for (int i = 0; i < 3; i++) begin
      if (t >= LATTICE_WIDTH) begin
        t = t - COORD_IN_W'(LATTICE_WIDTH);
      end
    end
    return X_W'(t);
  endfunction

  function automatic y_coord_t wrap_y(input logic [COORD_IN_W-1:0] v);
    logic [COORD_IN_W-1:0] t;
    t = v;
    for (int i = 0; i < 3; i++) begin
      if (t >= LATTICE_HEIGHT) begin
        t = t - COORD_IN_W'(LATTICE_HEIGHT);
      end
    end
    return Y_W'(t);
  endfunction

  function automatic site_addr_t site_addr(input x_coord_t x, input y_coord_t y);
    return ADDR_W'(y) * ADDR_W'(LATTICE_WIDTH) + ADDR_W'(x);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/isingm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module isingm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/isingm_ctrl.sv =====
// Controller state machine: input and output handshakes and read sequencing.
`default_nettype none
module isingm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output isingm_pkg::dp_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [isingm_pkg::SEL_W-1:0]     cnt;
  logic [isingm_pkg::SEL_W-1:0]     cnt_next;
  logic                             out_valid_next;
  logic                             out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.rd_sel     = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = isingm_pkg::SEL_CENTRE;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (cnt == isingm_pkg::SEL_DOWN) begin
          state_next = ST_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LAST: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= isingm_pkg::SEL_CENTRE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/isingm_datapath.sv =====
// Datapath: lattice store, neighbour count, acceptance test, spin sum and result register.
`default_nettype none
module isingm_datapath (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire isingm_pkg::dp_cmd_t                     cmd,
  input  wire logic                                    in_req,
  input  wire logic [isingm_pkg::COORD_IN_W-1:0]       in_x,
  input  wire logic [isingm_pkg::COORD_IN_W-1:0]       in_y,
  input  wire logic [isingm_pkg::RAND_W-1:0]           in_rand,
  input  wire logic                                    in_spin,
  input  wire logic                                    cfg_we,
  input  wire logic [isingm_pkg::CFG_INDEX_W-1:0]      cfg_idx,
  input  wire logic [isingm_pkg::THRESH_W-1:0]         cfg_wdata,
  output logic                                         res_flipped,
  output logic                                         res_spin,
  output logic signed [isingm_pkg::OUT_SUM_W-1:0]      res_sum
);

  logic                                   req_q;
  isingm_pkg::x_coord_t                   x_q;
  isingm_pkg::y_coord_t                   y_q;
  logic [isingm_pkg::RAND_W-1:0]          rnd_q;
  logic                                   sv_q;
  logic [isingm_pkg::THRESH_W-1:0]        thresh_low;
  logic [isingm_pkg::THRESH_W-1:0]        thresh_high;
  logic [isingm_pkg::SITE_COUNT-1:0]      written;
  logic signed [isingm_pkg::SUM_W-1:0]    total;
  logic signed [isingm_pkg::SUM_W-1:0]    total_next;
  logic                                   pend;
  logic [isingm_pkg::SEL_W-1:0]           pend_sel;
  logic                                   vld_q;
  logic [0:0]                             ram_q;
  logic                                   rd_spin;
  logic                                   centre_q;
  logic [isingm_pkg::NB_CNT_W-1:0]        up_cnt;
  logic [isingm_pkg::NB_CNT_W-1:0]        agree;
  isingm_pkg::site_addr_t                 centre_addr;
  isingm_pkg::site_addr_t                 rd_addr;
  isingm_pkg::x_coord_t                   x_left;
  isingm_pkg::x_coord_t                   x_right;
  isingm_pkg::y_coord_t                   y_up;
  isingm_pkg::y_coord_t                   y_down;
  logic                                   accept;
  logic                                   flip;
  logic                                   new_spin;

  assign x_left  = (x_q == '0) ? isingm_pkg::X_W'(isingm_pkg::LATTICE_WIDTH - 1)
                               : x_q - 1'b1;
  assign x_right = (x_q == isingm_pkg::X_W'(isingm_pkg::LATTICE_WIDTH - 1)) ? '0
                               : x_q + 1'b1;
  assign y_down  = (y_q == '0) ? isingm_pkg::Y_W'(isingm_pkg::LATTICE_HEIGHT - 1)
                               : y_q - 1'b1;
  assign y_up    = (y_q == isingm_pkg::Y_W'(isingm_pkg::LATTICE_HEIGHT - 1)) ? '0
                               : y_q + 1'b1;

  assign centre_addr = isingm_pkg::site_addr(x_q, y_q);

  always_comb begin
    case (cmd.rd_sel)
      isingm_pkg::SEL_CENTRE: rd_addr = centre_addr;
      isingm_pkg::SEL_LEFT:   rd_addr = isingm_pkg::site_addr(x_left, y_q);
      isingm_pkg::SEL_RIGHT:  rd_addr = isingm_pkg::site_addr(x_right, y_q);
      isingm_pkg::SEL_UP:     rd_addr = isingm_pkg::site_addr(x_q, y_up);
      isingm_pkg::SEL_DOWN:   rd_addr = isingm_pkg::site_addr(x_q, y_down);
      default:                rd_addr = centre_addr;
    endcase
  end

  isingm_ram #(
    .WIDTH (1),
    .DEPTH (isingm_pkg::SITE_COUNT)
  ) u_lattice (
    .clk   (clk),
    .we    (cmd.commit && flip),
    .waddr (centre_addr),
    .wdata (new_spin),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // A site never written still holds its reset spin, which is up.
  assign rd_spin = vld_q ? ram_q[0] : 1'b1;

  // Number of neighbours whose spin matches the centre; the energy product is 2*agree - 4.
  assign agree = centre_q ? up_cnt : isingm_pkg::NB_CNT_W'(4) - up_cnt;

  always_comb begin
    if (agree == isingm_pkg::NB_CNT_W'(4)) begin
      accept = {1'b0, rnd_q} < thresh_high;
    end else if (agree == isingm_pkg::NB_CNT_W'(3)) begin
      accept = {1'b0, rnd_q} < thresh_low;
    end else begin
      accept = 1'b1;
    end
  end

  assign flip       = (req_q == isingm_pkg::REQ_WRITE) ? (sv_q != centre_q) : accept;
  assign new_spin   = centre_q ^ flip;
  assign total_next = flip ? (new_spin ? total + isingm_pkg::SUM_W'(2)
                                       : total - isingm_pkg::SUM_W'(2))
                           : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_low  <= '0;
      thresh_high <= '0;
      written     <= '0;
      total       <= isingm_pkg::SUM_W'(isingm_pkg::SITE_COUNT);
      pend        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          isingm_pkg::CFG_THRESH_LOW:  thresh_low  <= cfg_wdata;
          isingm_pkg::CFG_THRESH_HIGH: thresh_high <= cfg_wdata;
          default: ;
        endcase
      end
      pend <= cmd.rd_en;
      if (cmd.commit && flip) begin
        written[centre_addr] <= 1'b1;
        total                <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= in_req;
      x_q    <= isingm_pkg::wrap_x(in_x);
      y_q    <= isingm_pkg::wrap_y(in_y);
      rnd_q  <= in_rand;
      sv_q   <= in_spin;
      up_cnt <= '0;
    end else if (pend) begin
      if (pend_sel == isingm_pkg::SEL_CENTRE) begin
        centre_q <= rd_spin;
      end else begin
        up_cnt <= up_cnt + isingm_pkg::NB_CNT_W'(rd_spin);
      end
    end
    if (cmd.rd_en) begin
      pend_sel <= cmd.rd_sel;
      vld_q    <= written[rd_addr];
    end
    if (cmd.commit) begin
      res_flipped <= flip;
      res_spin    <= new_spin;
      res_sum     <= isingm_pkg::OUT_SUM_W'(total_next);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ising_metropolis_spin_flip.sv =====
// Top level of the Ising Metropolis spin-flip block: port packing, controller and datapath.
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  one request word (tuser: kind)
//   m_axis    out        m_axis_tvalid/m_axis_tready  one result word per request
//   cfg       in         cfg_valid/cfg_ready          threshold register write
//
// Each request passes through five reads of the single-read-port lattice RAM, a wait for
// the last read data and a commit before the next request is accepted.
// The result word is registered at the commit.
// A held result stalls the commit, and no new request is taken until the commit is done.
// Reset leaves every spin up, the spin sum at the site count and both thresholds at zero.
`default_nettype none
module ising_metropolis_spin_flip (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // [2:0] site_x, [5:3] site_y, [21:6] rand_value, [22] spin_value, [23] zero
  input  wire logic [isingm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // [0] flipped, [1] site_spin, [9:2] spin_sum, [15:10] zero
  output logic [isingm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [isingm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [isingm_pkg::THRESH_W-1:0]       cfg_data
);

  isingm_pkg::dp_cmd_t                        cmd;
  logic                                       res_flipped;
  logic                                       res_spin;
  logic signed [isingm_pkg::OUT_SUM_W-1:0]    res_sum;

  assign cfg_ready = 1'b1;

  isingm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  isingm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_req      (s_axis_tuser),
    .in_x        (s_axis_tdata[2:0]),
    .in_y        (s_axis_tdata[5:3]),
    .in_rand     (s_axis_tdata[21:6]),
    .in_spin     (s_axis_tdata[22]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .res_flipped (res_flipped),
    .res_spin    (res_spin),
    .res_sum     (res_sum)
  );

  assign m_axis_tdata = {6'd0, res_sum, res_spin, res_flipped};

endmodule
`default_nettype wire

// ===== tb/tb_ising_metropolis_spin_flip.sv =====
// Self-checking testbench for the Ising Metropolis spin-flip block with a built-in lattice predictor.
`default_nettype none
module tb_ising_metropolis_spin_flip;

  typedef struct {
    logic                               req_kind;
    logic [isingm_pkg::COORD_IN_W-1:0]  x;
    logic [isingm_pkg::COORD_IN_W-1:0]  y;
    logic [isingm_pkg::RAND_W-1:0]      rnd_val;
    logic                               spin_val;
  } flip_request_t;

  typedef struct {
    logic                               flipped;
    logic                               site_spin;
    logic [isingm_pkg::OUT_SUM_W-1:0]   spin_sum;
  } flip_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [isingm_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
  logic                                 s_axis_tuser = isingm_pkg::REQ_ATTEMPT;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [isingm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [isingm_pkg::CFG_INDEX_W-1:0]   cfg_index = isingm_pkg::CFG_THRESH_LOW;
  logic [isingm_pkg::THRESH_W-1:0]      cfg_data = '0;

  flip_request_t pending_requests[$];
  flip_result_t  expected_results[$];

  // Predictor state: lattice, exact spin total and the two thresholds.
  bit                              model_lattice[isingm_pkg::SITE_COUNT];
  int                              model_total;
  logic [isingm_pkg::THRESH_W-1:0] model_thresh_low;
  logic [isingm_pkg::THRESH_W-1:0] model_thresh_high;

  // Threshold values last written, used to aim random values at the boundaries.
  int  set_thresh_low  = 0;
  int  set_thresh_high = 0;
  bit  calm = 1'b0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  always #5 clk = ~clk;

  ising_metropolis_spin_flip i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int spin_at(int unsigned x, int unsigned y);
    int unsigned idx;
    idx = (y % isingm_pkg::LATTICE_HEIGHT) * isingm_pkg::LATTICE_WIDTH
        + (x % isingm_pkg::LATTICE_WIDTH);
    return model_lattice[idx] ? 1 : -1;
  endfunction

  function automatic flip_result_t metropolis_step(flip_request_t r);
    int unsigned  cx;
    int unsigned  cy;
    int unsigned  idx;
    int           nsum;
    int           prod;
    bit           accept;
    bit           old_spin;
    bit           new_spin;
    flip_result_t res;
    cx = r.x % isingm_pkg::LATTICE_WIDTH;
    cy = r.y % isingm_pkg::LATTICE_HEIGHT;
    idx = cy * isingm_pkg::LATTICE_WIDTH + cx;
    old_spin = model_lattice[idx];
    new_spin = old_spin;
    if (r.req_kind == isingm_pkg::REQ_WRITE) begin
      new_spin = r.spin_val;
    end else begin
      nsum = spin_at(cx + isingm_pkg::LATTICE_WIDTH - 1, cy) + spin_at(cx + 1, cy)
           + spin_at(cx, cy + 1) + spin_at(cx, cy + isingm_pkg::LATTICE_HEIGHT - 1);
      prod = (old_spin ? 1 : -1) * nsum;
      if (prod <= 0) begin
        accept = 1'b1;
      end else if (prod == 2) begin
        accept = {1'b0, r.rnd_val} < model_thresh_low;
      end else begin
        accept = {1'b0, r.rnd_val} < model_thresh_high;
      end
      if (accept) begin
        new_spin = ~old_spin;
      end
    end
    if (new_spin != old_spin) begin
      model_total += new_spin ? 2 : -2;
      model_lattice[idx] = new_spin;
    end
    res.flipped   = new_spin != old_spin;
    res.site_spin = new_spin;
    res.spin_sum  = model_total[isingm_pkg::OUT_SUM_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : drive_requests
    flip_request_t nxt;
    logic          drive;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      drive = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (!calm && pending_requests.size() != 0 && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 3);
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        drive = 1'b1;
        s_axis_tdata <= {1'b0, nxt.spin_val, nxt.rnd_val, nxt.y, nxt.x};
        s_axis_tuser <= nxt.req_kind;
      end
      s_axis_tvalid <= drive;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_ports
    flip_request_t req;
    flip_result_t  want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == isingm_pkg::CFG_THRESH_LOW) begin
          model_thresh_low = cfg_data;
        end else if (cfg_index == isingm_pkg::CFG_THRESH_HIGH) begin
          model_thresh_high = cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.req_kind = s_axis_tuser;
        req.x        = s_axis_tdata[2:0];
        req.y        = s_axis_tdata[5:3];
        req.rnd_val  = s_axis_tdata[21:6];
        req.spin_val = s_axis_tdata[22];
        expected_results.push_back(metropolis_step(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none actual %h", $time,
                   m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[0] !== want.flipped) begin
            mismatches++;
            $display("%0t: flipped expected %b actual %b", $time, want.flipped, m_axis_tdata[0]);
          end
          if (m_axis_tdata[1] !== want.site_spin) begin
            mismatches++;
            $display("%0t: site_spin expected %b actual %b", $time, want.site_spin,
                     m_axis_tdata[1]);
          end
          if (m_axis_tdata[9:2] !== want.spin_sum) begin
            mismatches++;
            $display("%0t: spin_sum expected %0d actual %0d", $time, $signed(want.spin_sum),
                     $signed(m_axis_tdata[9:2]));
          end
        end
      end
    end
  end

  task automatic add_request(logic kind, int x, int y, int rnd, logic sv);
    flip_request_t r;
    r.req_kind = kind;
    r.x        = x[isingm_pkg::COORD_IN_W-1:0];
    r.y        = y[isingm_pkg::COORD_IN_W-1:0];
    r.rnd_val  = rnd[isingm_pkg::RAND_W-1:0];
    r.spin_val = sv;
    pending_requests.push_back(r);
  endtask

  task automatic add_random(int count);
    int rnd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        rnd = ($urandom_range(0, 1) ? set_thresh_low : set_thresh_high)
            + $urandom_range(0, 2) - 1;
        if (rnd < 0) rnd = 0;
        if (rnd > 65535) rnd = 65535;
      end else begin
        rnd = $urandom_range(0, 65535);
      end
      add_request($urandom_range(0, 3) == 0 ? isingm_pkg::REQ_WRITE : isingm_pkg::REQ_ATTEMPT,
                  $urandom_range(0, 7), $urandom_range(0, 7), rnd, $urandom_range(0, 1));
    end
  endtask

  // Checked on the falling edge so that every update of the rising edge has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [isingm_pkg::CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[isingm_pkg::THRESH_W-1:0];
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx == isingm_pkg::CFG_THRESH_LOW) begin
      set_thresh_low = value;
    end else begin
      set_thresh_high = value;
    end
  endtask

  task automatic set_thresholds(int low_val, int high_val);
    wait_drained();
    write_reg(isingm_pkg::CFG_THRESH_LOW, low_val);
    write_reg(isingm_pkg::CFG_THRESH_HIGH, high_val);
  endtask

  initial begin
    for (int i = 0; i < isingm_pkg::SITE_COUNT; i++) begin
      model_lattice[i] = 1'b1;
    end
    model_total       = isingm_pkg::SITE_COUNT;
    model_thresh_low  = '0;
    model_thresh_high = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // With both thresholds at zero only non-positive products may flip.
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 0, 1'b0);
    add_request(isingm_pkg::REQ_WRITE, 0, 0, 65535, 1'b0);
    add_request(isingm_pkg::REQ_WRITE, 0, 0, 0, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 65535, 1'b1);
    add_request(isingm_pkg::REQ_WRITE, 7, 0, 0, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 0, 1'b0);
    add_request(isingm_pkg::REQ_WRITE, 0, 7, 65535, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 65535, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 0, 1'b1);
    add_request(isingm_pkg::REQ_WRITE, 7, 7, 0, 1'b1);
    add_request(isingm_pkg::REQ_WRITE, 7, 7, 65535, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 7, 7, 0, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 6, 7, 65535, 1'b1);
    add_request(isingm_pkg::REQ_ATTEMPT, 7, 6, 0, 1'b0);
    add_request(isingm_pkg::REQ_WRITE, 3, 5, 12345, 1'b1);
    add_random(140);

    set_thresholds(65536, 65536);
    add_request(isingm_pkg::REQ_ATTEMPT, 4, 4, 65535, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 0, 0, 65535, 1'b1);
    add_random(150);

    set_thresholds(40000, 16000);
    add_random(250);

    set_thresholds(1, 0);
    add_request(isingm_pkg::REQ_ATTEMPT, 2, 2, 0, 1'b0);
    add_request(isingm_pkg::REQ_ATTEMPT, 5, 1, 1, 1'b1);
    add_random(150);

    set_thresholds($urandom_range(0, 65536), $urandom_range(0, 65536));
    add_random(250);

    set_thresholds(0, 65536);
    add_random(100);

    set_thresholds($urandom_range(0, 65536), $urandom_range(0, 65536));
    calm = 1'b1;
    add_random(100);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
